// File: hw/rtl/slm_pkg.sv
// Package for the sorted list merger: controller state type and fixed widths.
// Used by slm_ram.sv and sorted_list_merger_top.sv; depends on nothing.
package slm_pkg;

    // Width of one element, fixed by the element format.
    localparam int unsigned DATA_W = 32;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MSTART,
        ST_MERGE,
        ST_ERD,
        ST_ELOAD
    } t_state;

endpackage

// File: hw/rtl/sorted_list_merger_top.sv
// Sorted list merger: k-way merge of sorted lists by repeated two-way merging.
// Depends on slm_pkg.sv and slm_ram.sv.
//
// Input channel (i_in_valid / o_in_stall): one element per transfer with its
// list-end and set-end markers. On a list end the collected list is merged
// into the accumulated result held in a ping-pong merged memory, one merged
// element per cycle, set by the single read port of each memory and the
// read-compare-write loop.
// On a set end, after that merge, the merged sequence is sent on the output
// channel (o_out_valid / i_out_stall); each element is read from memory, then
// loaded into the output register. The last is marked by o_final_item, and
// o_overflow tells whether elements were dropped.
// The input is stalled while merging or emitting. The output register holds
// its element while the receiver stalls, and emission waits for it.
// Elements beyond CAPACITY are dropped and flagged; all counts clear once the
// last element of a set is loaded into the output register. Reset clears all
// counts and control state; memory contents are undefined until written and
// are never used before they are written.
module sorted_list_merger_top #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [slm_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_list_end,
    input  logic                               i_set_end,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [slm_pkg::DATA_W-1:0]  o_merged_value,
    output logic                               o_final_item,
    output logic                               o_overflow
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IDEPTH = 2 ** AW;
    localparam int unsigned MDEPTH = 2 ** (AW + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    slm_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_mcount, n_mcount;
    logic [CW-1:0] r_icount, n_icount;
    logic          r_dropped, n_dropped;
    logic          r_bank, n_bank;
    logic          r_set_end, n_set_end;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_e, n_e;

    logic                       r_out_valid, n_out_valid;
    logic [slm_pkg::DATA_W-1:0] r_out_value, n_out_value;
    logic                       r_out_final, n_out_final;
    logic                       r_out_ovf, n_out_ovf;

    // Memory port signals.
    logic                       inc_we;
    logic [AW-1:0]              inc_waddr;
    logic [AW-1:0]              inc_raddr;
    logic [slm_pkg::DATA_W-1:0] inc_rdata;
    logic                       mrg_we;
    logic [AW:0]                mrg_waddr;
    logic [slm_pkg::DATA_W-1:0] mrg_wdata;
    logic [AW:0]                mrg_raddr;
    logic [slm_pkg::DATA_W-1:0] mrg_rdata;

    logic in_xfer;
    logic out_free;
    logic a_ok;
    logic b_ok;
    logic take_a;

    // Incoming list store.
    slm_ram #(
        .DEPTH (IDEPTH),
        .WIDTH (slm_pkg::DATA_W)
    ) u_incoming (
        .i_clk   (i_clk),
        .i_we    (inc_we),
        .i_waddr (inc_waddr),
        .i_wdata (i_value),
        .i_raddr (inc_raddr),
        .o_rdata (inc_rdata)
    );

    // Merged store: two banks, the merge reads one and writes the other.
    slm_ram #(
        .DEPTH (MDEPTH),
        .WIDTH (slm_pkg::DATA_W)
    ) u_merged (
        .i_clk   (i_clk),
        .i_we    (mrg_we),
        .i_waddr (mrg_waddr),
        .i_wdata (mrg_wdata),
        .i_raddr (mrg_raddr),
        .o_rdata (mrg_rdata)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Merge choice: the accumulated element goes first only if strictly smaller.
    assign a_ok   = (r_i < r_mcount);
    assign b_ok   = (r_j < r_icount);
    assign take_a = a_ok && (!b_ok || ($signed(mrg_rdata) < $signed(inc_rdata)));

    // Next state, counters and memory controls.
    always_comb begin
        n_state     = r_state;
        n_mcount    = r_mcount;
        n_icount    = r_icount;
        n_dropped   = r_dropped;
        n_bank      = r_bank;
        n_set_end   = r_set_end;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_e         = r_e;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_final = r_out_final;
        n_out_ovf   = r_out_ovf;
        inc_we      = 1'b0;
        inc_waddr   = r_icount[AW-1:0];
        mrg_we      = 1'b0;
        mrg_waddr   = {~r_bank, r_k[AW-1:0]};
        mrg_wdata   = take_a ? mrg_rdata : inc_rdata;

        unique case (r_state)
            slm_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    // Store the element unless the incoming list is full.
                    if (r_icount != CAP) begin
                        inc_we   = 1'b1;
                        n_icount = r_icount + ONE;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_list_end || i_set_end) begin
                        n_set_end = i_set_end;
                        n_i       = '0;
                        n_j       = '0;
                        n_k       = '0;
                        n_state   = slm_pkg::ST_MSTART;
                    end
                end
            end

            slm_pkg::ST_MSTART: begin
                // Read addresses for both heads are presented this cycle.
                n_state = slm_pkg::ST_MERGE;
            end

            slm_pkg::ST_MERGE: begin
                if ((!a_ok && !b_ok) || (r_k == CAP)) begin
                    // Merge finished; anything left over is lost.
                    if (a_ok || b_ok) begin
                        n_dropped = 1'b1;
                    end
                    n_mcount = r_k;
                    n_icount = '0;
                    n_bank   = ~r_bank;
                    n_e      = '0;
                    if (!r_set_end) begin
                        n_state = slm_pkg::ST_IDLE;
                    end else if (r_k != '0) begin
                        n_state = slm_pkg::ST_ERD;
                    end else begin
                        n_mcount  = '0;
                        n_dropped = 1'b0;
                        n_state   = slm_pkg::ST_IDLE;
                    end
                end else begin
                    // Write the smaller head and advance its side.
                    mrg_we = 1'b1;
                    n_k    = r_k + ONE;
                    if (take_a) begin
                        n_i = r_i + ONE;
                    end else begin
                        n_j = r_j + ONE;
                    end
                end
            end

            slm_pkg::ST_ERD: begin
                n_state = slm_pkg::ST_ELOAD;
            end

            slm_pkg::ST_ELOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = mrg_rdata;
                    n_out_final = (r_e + ONE == r_mcount);
                    n_out_ovf   = r_dropped;
                    if (r_e + ONE == r_mcount) begin
                        // Last transfer of the set: empty all stores.
                        n_mcount  = '0;
                        n_icount  = '0;
                        n_dropped = 1'b0;
                        n_e       = '0;
                        n_state   = slm_pkg::ST_IDLE;
                    end else begin
                        n_e     = r_e + ONE;
                        n_state = slm_pkg::ST_ERD;
                    end
                end
            end

            default: begin
                n_state = slm_pkg::ST_IDLE;
            end
        endcase
    end

    // Read addresses follow the next head indexes during a merge.
    always_comb begin
        inc_raddr = n_j[AW-1:0];
        if (r_state == slm_pkg::ST_MSTART || r_state == slm_pkg::ST_MERGE) begin
            mrg_raddr = {r_bank, n_i[AW-1:0]};
        end else begin
            mrg_raddr = {r_bank, r_e[AW-1:0]};
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slm_pkg::ST_IDLE;
            r_mcount    <= '0;
            r_icount    <= '0;
            r_dropped   <= 1'b0;
            r_bank      <= 1'b0;
            r_set_end   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_e         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mcount    <= n_mcount;
            r_icount    <= n_icount;
            r_dropped   <= n_dropped;
            r_bank      <= n_bank;
            r_set_end   <= n_set_end;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_e         <= n_e;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_final <= n_out_final;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_in_stall     = (r_state != slm_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_final_item   = r_out_final;
    assign o_overflow     = r_out_ovf;

endmodule

// File: hw/rtl/slm_ram.sv
// Simple dual-port RAM: one write port and one read port, read data registered.
// Uses slm_pkg for the default data width.
module slm_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = slm_pkg::DATA_W,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for sorted_list_merger_top: directed and random sets of
// sorted and unsorted lists, checked against a behavioral merge predictor in this file.
// Depends on slm_pkg.sv, slm_ram.sv and sorted_list_merger_top.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DATA_W       = slm_pkg::DATA_W;
    localparam int unsigned CAP          = 64;
    localparam int          CLK_PERIOD   = 12;
    localparam int          RESET_CYCLES = 9;
    localparam int          RANDOM_ITEMS = 420;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          DRAIN_CYCLES = 2 * CAP + 40;

    // Traffic phases: how often each side idles.
    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_phase;

    // Shapes of randomly generated sets.
    typedef enum int {
        K_ORDERED,
        K_NOISE,
        K_MERGE_OVF,
        K_LIST_OVF
    } t_set_kind;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     list_end;
        logic                     set_end;
        t_phase                   phase;
    } t_transfer;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     final_item;
        logic                     overflow;
    } t_merged;

    int unsigned idle_pct  [5] = '{0, 68, 0, 29, 0};
    int unsigned stall_pct [5] = '{0, 0, 68, 29, 0};

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic                     i_list_end  = 1'b0;
    logic                     i_set_end   = 1'b0;
    logic                     i_out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_merged_value;
    logic                     o_final_item;
    logic                     o_overflow;

    t_transfer stimulus_q [$];
    t_merged   merged_expect_q [$];

    // Predictor state: accumulated merge result and the list being collected.
    logic signed [DATA_W-1:0] acc_store  [CAP];
    logic signed [DATA_W-1:0] list_store [CAP];
    int                       acc_count  = 0;
    int                       list_count = 0;
    logic                     dropped    = 1'b0;

    t_phase cur_phase     = PH_FREE;
    int     hold_left     = 0;
    bit     pressure_done = 1'b0;
    int     errors        = 0;
    int     transfers_in  = 0;
    int     results_out   = 0;
    int     sets_out      = 0;
    int     overflow_sets = 0;
    int     held_in_stall = 0;

    sorted_list_merger_top #(
        .CAPACITY(CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_list_end     (i_list_end),
        .i_set_end      (i_set_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_merged_value (o_merged_value),
        .o_final_item   (o_final_item),
        .o_overflow     (o_overflow)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Advance the predictor by one accepted element and queue any merged output.
    task automatic predict_merge(input logic signed [DATA_W-1:0] v, input logic lend,
                                 input logic send);
        logic signed [DATA_W-1:0] merged_tmp [CAP];
        logic signed [DATA_W-1:0] pick;
        int                       ia;
        int                       ib;
        int                       k;
        t_merged                  r;
        if (list_count < CAP) begin
            list_store[list_count] = v;
            list_count++;
        end else begin
            dropped = 1'b1;
        end
        // A set end closes the current list as well.
        if (lend || send) begin
            ia = 0;
            ib = 0;
            k  = 0;
            while (ia < acc_count || ib < list_count) begin
                // The accumulated side wins only when strictly smaller.
                if (ia < acc_count && (ib >= list_count || acc_store[ia] < list_store[ib])) begin
                    pick = acc_store[ia];
                    ia++;
                end else begin
                    pick = list_store[ib];
                    ib++;
                end
                if (k < CAP) begin
                    merged_tmp[k] = pick;
                    k++;
                end else begin
                    dropped = 1'b1;
                end
            end
            for (int n = 0; n < k; n++) begin
                acc_store[n] = merged_tmp[n];
            end
            acc_count  = k;
            list_count = 0;
        end
        if (send) begin
            for (int n = 0; n < acc_count; n++) begin
                r.value      = acc_store[n];
                r.final_item = (n == acc_count - 1);
                r.overflow   = dropped;
                merged_expect_q.insert(merged_expect_q.size(), r);
            end
            acc_count  = 0;
            list_count = 0;
            dropped    = 1'b0;
        end
    endtask

    // Mix of full-range words, values near zero, and values near both extremes.
    function automatic logic signed [DATA_W-1:0] random_word();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            return $urandom;
        end else if (sel < 70) begin
            return $signed($urandom_range(12)) - 6;
        end else if (sel < 85) begin
            return 32'sh8000_0000 + $urandom_range(20);
        end else begin
            return 32'sh7fff_ffff - $urandom_range(20);
        end
    endfunction

    task automatic queue_elem(input logic signed [DATA_W-1:0] v, input logic lend,
                              input logic send, input t_phase ph);
        t_transfer t;
        t.value    = v;
        t.list_end = lend;
        t.set_end  = send;
        t.phase    = ph;
        stimulus_q.insert(stimulus_q.size(), t);
    endtask

    // One list; ordered lists climb by ties, small steps and big jumps.
    task automatic queue_list(input int len, input bit ordered, input bit closes_set,
                              input t_phase ph);
        longint cur;
        bit     last;
        cur = random_word();
        for (int n = 0; n < len; n++) begin
            if (!ordered) begin
                cur = random_word();
            end else if (n > 0) begin
                case ($urandom_range(3))
                    0: begin
                        cur = cur;
                    end
                    1, 2: begin
                        cur = cur + $urandom_range(1000);
                    end
                    default: begin
                        cur = cur + $urandom_range(32'h7fff_ffff);
                    end
                endcase
                if (cur > 64'sd2147483647) begin
                    cur = 64'sd2147483647;
                end
            end
            last = (n == len - 1);
            // The closing element of a set sometimes omits its list-end marker.
            queue_elem(cur[DATA_W-1:0], last && (!closes_set || $urandom_range(1) == 1),
                       last && closes_set, ph);
        end
    endtask

    // Driver: offers queued transfers, idling at random between them.
    always @(posedge i_clk) begin : drive_inputs
        logic      taken;
        t_transfer t;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                predict_merge(i_value, i_list_end, i_set_end);
                transfers_in++;
            end
            if ((!i_in_valid || taken) && stimulus_q.size() > 0
                    && $urandom_range(99) >= idle_pct[stimulus_q[0].phase]) begin
                t = stimulus_q.pop_front();
                cur_phase  <= t.phase;
                i_in_valid <= 1'b1;
                i_value    <= t.value;
                i_list_end <= t.list_end;
                i_set_end  <= t.set_end;
            end else if (taken || !i_in_valid) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when pressure begins.
    always @(posedge i_clk) begin : drive_receiver
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
            if (i_in_valid && o_in_stall) begin
                held_in_stall++;
            end
        end else if (cur_phase == PH_PRESSURE && !pressure_done) begin
            i_out_stall   <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct[cur_phase]);
        end
    end

    // Monitor: each output transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_outputs
        t_merged want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_out++;
            if (o_final_item) begin
                sets_out++;
                if (o_overflow) begin
                    overflow_sets++;
                end
            end
            if (merged_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output transfer, value %0d final %b overflow %b",
                         $realtime, o_merged_value, o_final_item, o_overflow);
            end else begin
                want = merged_expect_q.pop_front();
                if (o_merged_value !== want.value) begin
                    errors++;
                    $display("%0t: merged_value expected %0d, actual %0d",
                             $realtime, want.value, o_merged_value);
                end
                if (o_final_item !== want.final_item) begin
                    errors++;
                    $display("%0t: final_item expected %b, actual %b",
                             $realtime, want.final_item, o_final_item);
                end
                if (o_overflow !== want.overflow) begin
                    errors++;
                    $display("%0t: overflow expected %b, actual %b",
                             $realtime, want.overflow, o_overflow);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int        random_items;
        int        set_idx;
        int        n_lists;
        int        before_len;
        t_phase    ph;
        t_set_kind kind;

        // Directed: a lone element closing a set without a list-end marker.
        queue_elem(32'sh7fff_ffff, 1'b0, 1'b1, PH_FREE);
        // Two lists with extremes and ties between them.
        queue_elem(32'sh8000_0000, 1'b0, 1'b0, PH_FREE);
        queue_elem(-1, 1'b0, 1'b0, PH_FREE);
        queue_elem(0, 1'b1, 1'b0, PH_FREE);
        queue_elem(-1, 1'b0, 1'b0, PH_FREE);
        queue_elem(-1, 1'b0, 1'b0, PH_FREE);
        queue_elem(32'sh7fff_ffff, 1'b1, 1'b1, PH_FREE);
        // Unsorted lists are merged by the same rule.
        queue_elem(5, 1'b0, 1'b0, PH_FREE);
        queue_elem(-3, 1'b0, 1'b0, PH_FREE);
        queue_elem(9, 1'b1, 1'b0, PH_FREE);
        queue_elem(2, 1'b0, 1'b0, PH_FREE);
        queue_elem(-7, 1'b0, 1'b1, PH_FREE);
        // Single-element lists.
        queue_elem(0, 1'b1, 1'b0, PH_FREE);
        queue_elem(32'sh8000_0000, 1'b1, 1'b0, PH_FREE);
        queue_elem(32'sh7fff_ffff, 1'b1, 1'b0, PH_FREE);
        queue_elem(-1, 1'b1, 1'b1, PH_FREE);
        // Alternating bit patterns.
        queue_elem(32'shaaaa_aaaa, 1'b0, 1'b0, PH_FREE);
        queue_elem(32'sh5555_5555, 1'b1, 1'b1, PH_FREE);

        // Random sets; the phase follows the number of items generated so far.
        random_items = 0;
        set_idx      = 0;
        while (random_items < RANDOM_ITEMS) begin
            before_len = stimulus_q.size();
            if (random_items < 100) begin
                ph = PH_FREE;
            end else if (random_items < 200) begin
                ph = PH_SEND_IDLE;
            end else if (random_items < 300) begin
                ph = PH_RECV_STALL;
            end else if (random_items < 350) begin
                ph = PH_PRESSURE;
            end else begin
                ph = PH_BOTH;
            end
            // Both overflow cases are forced early, then drawn at random.
            if (set_idx == 1) begin
                kind = K_MERGE_OVF;
            end else if (set_idx == 3) begin
                kind = K_LIST_OVF;
            end else begin
                case ($urandom_range(19))
                    0, 1: kind = K_MERGE_OVF;
                    2:    kind = K_LIST_OVF;
                    3, 4, 5: kind = K_NOISE;
                    default: kind = K_ORDERED;
                endcase
            end
            case (kind)
                K_MERGE_OVF: begin
                    n_lists = $urandom_range(3, 2);
                    for (int l = 0; l < n_lists; l++) begin
                        queue_list($urandom_range(40, 22), 1'b1, l == n_lists - 1, ph);
                    end
                end
                K_LIST_OVF: begin
                    queue_list($urandom_range(72, 65), 1'b1, 1'b1, ph);
                end
                default: begin
                    n_lists = $urandom_range(5, 1);
                    for (int l = 0; l < n_lists; l++) begin
                        queue_list($urandom_range(12, 1), kind == K_ORDERED,
                                   l == n_lists - 1, ph);
                    end
                end
            endcase
            random_items += stimulus_q.size() - before_len;
            set_idx++;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stimulus_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (merged_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d element transfers; checked %0d merged outputs in %0d sets.",
                 transfers_in, results_out, sets_out);
        $display("Sets with dropped elements: %0d; input stalled %0d cycles under hold-off.",
                 overflow_sets, held_in_stall);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Timeout: %0d transfers still queued, %0d outputs still expected.",
                 stimulus_q.size(), merged_expect_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
